>>> hdl/pdwt_pkg.sv
// Shared types, codes and constants of the PCI DMA window translator.
// No dependencies; imported by every module in hdl/.
package pdwt_pkg;

    // Default window count, handed to the top-level parameter
    localparam int NUM_WINDOWS_DEF = 4;

    // Function codes of an incoming transfer
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_XLATE = 2'd2;
    localparam logic [1:0] FUNC_ENTRY = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_FETCH = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // Register groups (upper two bits of the register index)
    localparam logic [1:0] GRP_BASE  = 2'd0;
    localparam logic [1:0] GRP_MASK  = 2'd1;
    localparam logic [1:0] GRP_TBASE = 2'd2;
    localparam logic [1:0] GRP_MISC  = 2'd3;

    // Registers of the miscellaneous group
    localparam logic [3:0] REG_CTRL    = 4'd12;
    localparam logic [3:0] REG_ERR     = 4'd13;
    localparam logic [3:0] REG_ERRMASK = 4'd14;
    localparam logic [3:0] REG_TLBIA   = 4'd15;

    // Address masks
    localparam logic [63:0] ADDR34_MASK = 64'h0000_0003_FFFF_FFFF;
    localparam logic [63:0] CMP_BITS    = 64'h0000_0000_FFF0_0000;
    localparam logic [63:0] LOW20       = 64'h0000_0000_000F_FFFF;
    localparam logic [63:0] PAGE_BITS   = 64'h0000_0000_000F_E000;
    localparam logic [63:0] LOW10       = 64'h0000_0000_0000_03FF;
    localparam logic [63:0] CTRL_RESET  = 64'h0000_0021_0010_0000;

    localparam int OFFSET_W = 13;

    // Translation outcome handed from the window matcher to the top level
    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
        logic        fetch;
    } xlate_t;

endpackage

>>> hdl/pci_dma_window_translator_unit.sv
// PCI DMA window translator, top level. Uses pdwt_pkg, pdwt_window_bank, pdwt_xlate.
// A transfer passes the input register, then the window compare into the result
// register, which drives the result strobe (done).
// Throughput: one transfer per cycle; busy stays low, results are never held.
// Reset (rst_n low, async) clears all windows, sets control to its default,
// drops any pending page entry and empties both pipeline registers.
module pci_dma_window_translator_unit #(
    parameter int NUM_WINDOWS = pdwt_pkg::NUM_WINDOWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [3:0]  reg_index,
    input  logic [63:0] write_data,
    input  logic [63:0] bus_address,
    input  logic [63:0] page_entry,
    output logic        done,
    output logic [1:0]  kind,
    output logic [63:0] data
);
    import pdwt_pkg::*;

    // Input register
    logic        in_vld_reg;
    logic [1:0]  func_reg;
    logic [3:0]  idx_reg;
    logic [63:0] wdata_reg;
    logic [63:0] addr_reg;
    logic [63:0] pe_reg;

    // Bridge state
    logic [63:0]         ctrl_reg, ctrl_next;
    logic                pend_reg, pend_next;
    logic [OFFSET_W-1:0] off_reg, off_next;

    // Result register
    logic        done_reg;
    logic [1:0]  kind_reg, kind_next;
    logic [63:0] data_reg, data_next;

    logic        wr_en;
    logic        win_ok;
    logic [1:0]  grp;
    logic [1:0]  win;
    logic [63:0] rd_data;
    logic [63:0] base  [NUM_WINDOWS];
    logic [63:0] mask  [NUM_WINDOWS];
    logic [63:0] tbase [NUM_WINDOWS];
    xlate_t      xl;

    assign busy = 1'b0;
    assign grp  = idx_reg[3:2];
    assign win  = idx_reg[1:0];
    assign win_ok = int'(win) < NUM_WINDOWS;

    // Capture the incoming transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg  <= func;
            idx_reg   <= reg_index;
            wdata_reg <= write_data;
            addr_reg  <= bus_address;
            pe_reg    <= page_entry;
        end
    end

    pdwt_window_bank #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .grp     (grp),
        .win     (win),
        .wr_data (wdata_reg),
        .rd_data (rd_data),
        .base    (base),
        .mask    (mask),
        .tbase   (tbase)
    );

    pdwt_xlate #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_xlate (
        .addr  (addr_reg),
        .base  (base),
        .mask  (mask),
        .tbase (tbase),
        .res   (xl)
    );

    // Decode and execute the registered transfer
    always_comb
    begin
        kind_next = KIND_ACK;
        data_next = '0;
        wr_en     = 1'b0;
        ctrl_next = ctrl_reg;
        pend_next = pend_reg;
        off_next  = off_reg;
        if (in_vld_reg)
        begin
            unique case (func_reg)
                FUNC_WRITE:
                begin
                    if (grp != GRP_MISC)
                    begin
                        if (win_ok)
                            wr_en = 1'b1;
                        else
                            kind_next = KIND_ERR;
                    end
                    else if (idx_reg == REG_CTRL)
                        ctrl_next = wdata_reg;
                    else if (idx_reg == REG_ERRMASK)
                        kind_next = KIND_ERR;
                    // error and tlb invalidate writes: plain ack
                end
                FUNC_READ:
                begin
                    if (grp != GRP_MISC)
                    begin
                        if (win_ok)
                            data_next = rd_data;
                        else
                            kind_next = KIND_ERR;
                    end
                    else if (idx_reg == REG_CTRL)
                        data_next = ctrl_reg;
                end
                FUNC_XLATE:
                begin
                    kind_next = xl.kind;
                    data_next = xl.data;
                    pend_next = xl.fetch;
                    if (xl.fetch)
                        off_next = addr_reg[OFFSET_W-1:0];
                end
                FUNC_ENTRY:
                begin
                    if (pend_reg)
                    begin
                        // entry bit 0 cleared, shifted to bit 12, limited to 34 bits
                        kind_next = KIND_ADDR;
                        data_next = {30'd0, pe_reg[21:1], off_reg};
                        pend_next = 1'b0;
                    end
                    else
                        kind_next = KIND_ERR;
                end
                default:
                    kind_next = KIND_ERR;
            endcase
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= CTRL_RESET;
            pend_reg <= 1'b0;
            off_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
            pend_reg <= pend_next;
            off_reg  <= off_next;
            done_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
    end

    assign done = done_reg;
    assign kind = kind_reg;
    assign data = data_reg;

    // Every accepted transfer is answered, through the input and result registers
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted transfer not answered after two cycles");

    // Errors carry zero data
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_ERR) |-> data == '0)
        else $error("error result with nonzero data");

    // A pending page entry only starts alongside a fetch request
    a_pend_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pend_reg) |-> (done && kind == KIND_FETCH))
        else $error("pending entry set without fetch request");

    // A fetch request always leaves an entry pending
    a_fetch_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_FETCH) |-> pend_reg)
        else $error("fetch request issued without pending entry");

endmodule

>>> hdl/pdwt_window_bank.sv
// Window register bank: base, mask and translated base per DMA window.
// Depends on pdwt_pkg.
module pdwt_window_bank #(
    parameter int NUM_WINDOWS = pdwt_pkg::NUM_WINDOWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  grp,
    input  logic [1:0]  win,
    input  logic [63:0] wr_data,
    output logic [63:0] rd_data,
    output logic [63:0] base  [NUM_WINDOWS],
    output logic [63:0] mask  [NUM_WINDOWS],
    output logic [63:0] tbase [NUM_WINDOWS]
);
    import pdwt_pkg::*;

    logic [63:0] base_reg  [NUM_WINDOWS];
    logic [63:0] mask_reg  [NUM_WINDOWS];
    logic [63:0] tbase_reg [NUM_WINDOWS];

    // One register set per window
    for (genvar i = 0; i < NUM_WINDOWS; i++) begin : g_win
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                base_reg[i]  <= '0;
                mask_reg[i]  <= '0;
                tbase_reg[i] <= '0;
            end
            else if (wr_en && int'(win) == i)
            begin
                if (grp == GRP_BASE)
                    base_reg[i] <= wr_data;
                if (grp == GRP_MASK)
                    mask_reg[i] <= wr_data;
                if (grp == GRP_TBASE)
                    tbase_reg[i] <= wr_data;
            end
        end

        assign base[i]  = base_reg[i];
        assign mask[i]  = mask_reg[i];
        assign tbase[i] = tbase_reg[i];
    end

    // Register read select
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < NUM_WINDOWS; i++)
        begin
            if (int'(win) == i)
            begin
                unique case (grp)
                    GRP_BASE:  rd_data = base_reg[i];
                    GRP_MASK:  rd_data = mask_reg[i];
                    GRP_TBASE: rd_data = tbase_reg[i];
                    default:   rd_data = '0;
                endcase
            end
        end
    end

endmodule

>>> hdl/pdwt_xlate.sv
// Window matcher: parallel compare of all windows, priority pick, address build.
// Depends on pdwt_pkg.
module pdwt_xlate #(
    parameter int NUM_WINDOWS = pdwt_pkg::NUM_WINDOWS_DEF
) (
    input  logic [63:0]     addr,
    input  logic [63:0]     base  [NUM_WINDOWS],
    input  logic [63:0]     mask  [NUM_WINDOWS],
    input  logic [63:0]     tbase [NUM_WINDOWS],
    output pdwt_pkg::xlate_t res
);
    import pdwt_pkg::*;

    // Lowest-numbered enabled window that matches wins; walk down so it lands last
    always_comb
    begin
        logic [63:0] cmp;
        logic [63:0] amask;
        logic [63:0] tmask;
        cmp       = '0;
        amask     = '0;
        tmask     = '0;
        res.kind  = KIND_ADDR;
        res.data  = addr;
        res.fetch = 1'b0;
        for (int i = NUM_WINDOWS - 1; i >= 0; i--)
        begin
            cmp = ~mask[i] & CMP_BITS;
            if (((addr ^ base[i]) & cmp) == '0 && base[i][0])
            begin
                if (base[i][1])
                begin
                    // scatter-gather: page table entry fetch address
                    tmask = ~(((mask[i] & CMP_BITS) >> 10) | LOW10);
                    amask = (mask[i] & CMP_BITS) | PAGE_BITS;
                    res.kind  = KIND_FETCH;
                    res.data  = (tbase[i] & tmask) | ((addr & amask) >> 10);
                    res.fetch = 1'b1;
                end
                else
                begin
                    // direct window
                    amask = (mask[i] & CMP_BITS) | LOW20;
                    res.kind  = KIND_ADDR;
                    res.data  = ((tbase[i] & ~amask) | (addr & amask)) & ADDR34_MASK;
                    res.fetch = 1'b0;
                end
            end
        end
    end

endmodule

>>> bench/pdwt_checker.sv
// Scoreboard for the PCI DMA window translator: keeps its own copy of the bridge
// registers, predicts the single result of every accepted transfer and checks the strobe.
// Depends on pdwt_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module pdwt_checker #(
    parameter int NUM_WINDOWS = pdwt_pkg::NUM_WINDOWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [3:0]  reg_index,
    input  logic [63:0] write_data,
    input  logic [63:0] bus_address,
    input  logic [63:0] page_entry,
    input  logic        done,
    input  logic [1:0]  kind,
    input  logic [63:0] data,
    output int unsigned fail_count,
    output int unsigned outstanding,
    output int unsigned ack_count,
    output int unsigned addr_count,
    output int unsigned fetch_count,
    output int unsigned err_count
);
    import pdwt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] data;
    } bridge_result_t;

    // Mirror of the bridge state
    logic [63:0]         win_base  [NUM_WINDOWS];
    logic [63:0]         win_mask  [NUM_WINDOWS];
    logic [63:0]         win_xbase [NUM_WINDOWS];
    logic [63:0]         ctrl_reg;
    logic                entry_due;
    logic [OFFSET_W-1:0] held_offset;

    // Results still owed by the block, oldest first
    bridge_result_t      owed_results [$];
    bridge_result_t      oldest;

    task automatic clear_bridge_state();
        for (int i = 0; i < NUM_WINDOWS; i++)
        begin
            win_base[i]  = '0;
            win_mask[i]  = '0;
            win_xbase[i] = '0;
        end
        ctrl_reg    = CTRL_RESET;
        entry_due   = 1'b0;
        held_offset = '0;
    endtask

    // Applies one transfer to the mirror and returns the result it must give
    function automatic bridge_result_t bridge_response(
        input logic [1:0]  fn,
        input logic [3:0]  idx,
        input logic [63:0] wd,
        input logic [63:0] ba,
        input logic [63:0] pe
    );
        bridge_result_t res;
        logic [1:0]     grp;
        int             w;
        logic           hit;
        logic [63:0]    cmp;
        logic [63:0]    sel;

        res.kind = KIND_ACK;
        res.data = '0;
        grp      = idx[3:2];
        w        = int'(idx[1:0]);
        hit      = 1'b0;

        case (fn)
            FUNC_WRITE:
            begin
                if (grp != GRP_MISC)
                begin
                    if (w >= NUM_WINDOWS)
                        res.kind = KIND_ERR;
                    else if (grp == GRP_BASE)
                        win_base[w] = wd;
                    else if (grp == GRP_MASK)
                        win_mask[w] = wd;
                    else
                        win_xbase[w] = wd;
                end
                else if (idx == REG_CTRL)
                    ctrl_reg = wd;
                else if (idx == REG_ERRMASK)
                    res.kind = KIND_ERR;
            end
            FUNC_READ:
            begin
                if (grp != GRP_MISC)
                begin
                    if (w >= NUM_WINDOWS)
                        res.kind = KIND_ERR;
                    else if (grp == GRP_BASE)
                        res.data = win_base[w];
                    else if (grp == GRP_MASK)
                        res.data = win_mask[w];
                    else
                        res.data = win_xbase[w];
                end
                else if (idx == REG_CTRL)
                    res.data = ctrl_reg;
            end
            FUNC_XLATE:
            begin
                // any outstanding page entry is dropped; unmatched addresses pass through
                entry_due = 1'b0;
                res.kind  = KIND_ADDR;
                res.data  = ba;
                for (int i = 0; i < NUM_WINDOWS; i++)
                begin
                    cmp = ~win_mask[i] & CMP_BITS;
                    if (!hit && win_base[i][0] && ((ba & cmp) == (win_base[i] & cmp)))
                    begin
                        hit = 1'b1;
                        sel = win_mask[i] & CMP_BITS;
                        if (win_base[i][1])
                        begin
                            // scatter-gather: ask for the page table entry first
                            res.kind    = KIND_FETCH;
                            res.data    = (win_xbase[i] & ~((sel >> 10) | LOW10))
                                        | ((ba & (sel | PAGE_BITS)) >> 10);
                            held_offset = ba[OFFSET_W-1:0];
                            entry_due   = 1'b1;
                        end
                        else
                        begin
                            res.data = ((win_xbase[i] & ~(sel | LOW20)) | (ba & (sel | LOW20)))
                                     & ADDR34_MASK;
                        end
                    end
                end
            end
            default:
            begin
                // page entry return: only legal while a fetch request is pending
                if (!entry_due)
                    res.kind = KIND_ERR;
                else
                begin
                    res.kind = KIND_ADDR;
                    res.data = (({pe[63:1], 1'b0} << 12)
                             | {{(64 - OFFSET_W){1'b0}}, held_offset}) & ADDR34_MASK;
                end
                entry_due = 1'b0;
            end
        endcase
        return res;
    endfunction

    // Predict on every accepted transfer, check on every result strobe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_bridge_state();
            owed_results.delete();
            fail_count  = 0;
            ack_count   = 0;
            addr_count  = 0;
            fetch_count = 0;
            err_count   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (start && !busy)
                owed_results.push_back(bridge_response(func, reg_index, write_data,
                                                       bus_address, page_entry));
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t ERROR: unexpected result, kind %0d data %h",
                             $time, kind, data);
                    fail_count++;
                end
                else
                begin
                    oldest = owed_results.pop_front();
                    if (kind !== oldest.kind)
                    begin
                        $display("%0t ERROR: kind expected %0d, got %0d",
                                 $time, oldest.kind, kind);
                        fail_count++;
                    end
                    if (data !== oldest.data)
                    begin
                        $display("%0t ERROR: data expected %h, got %h",
                                 $time, oldest.data, data);
                        fail_count++;
                    end
                    case (oldest.kind)
                        KIND_ACK:   ack_count++;
                        KIND_ADDR:  addr_count++;
                        KIND_FETCH: fetch_count++;
                        default:    err_count++;
                    endcase
                end
            end
            outstanding <= owed_results.size();
        end
    end

endmodule

>>> bench/tb_pci_dma_window_translator_unit.sv
// Testbench top for the PCI DMA window translator: drives directed and random
// transfers in bursts and gives the verdict. Depends on pdwt_pkg and pdwt_checker.
`timescale 1ns / 100ps

module tb_pci_dma_window_translator_unit;
    import pdwt_pkg::*;

    localparam int ITEM_TARGET    = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [3:0]  reg_index;
    logic [63:0] write_data;
    logic [63:0] bus_address;
    logic [63:0] page_entry;
    logic        done;
    logic [1:0]  kind;
    logic [63:0] data;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned ack_count;
    int unsigned addr_count;
    int unsigned fetch_count;
    int unsigned err_count;

    int unsigned sent_count  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    // Last values written to base and mask, used to aim addresses at windows
    logic [63:0] aim_base [NUM_WINDOWS_DEF];
    logic [63:0] aim_mask [NUM_WINDOWS_DEF];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pci_dma_window_translator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .bus_address (bus_address),
        .page_entry  (page_entry),
        .done        (done),
        .kind        (kind),
        .data        (data)
    );

    pdwt_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .bus_address (bus_address),
        .page_entry  (page_entry),
        .done        (done),
        .kind        (kind),
        .data        (data),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .ack_count   (ack_count),
        .addr_count  (addr_count),
        .fetch_count (fetch_count),
        .err_count   (err_count)
    );

    // Watchdog: ends the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ERROR: no transfer for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random register index for transfers that ignore it
    function automatic logic [3:0] rand_idx();
        return 4'($urandom_range(0, 15));
    endfunction

    // Register values that make windows useful: mostly enabled, contiguous masks
    function automatic logic [63:0] window_value(input logic [1:0] grp);
        logic [63:0] v;
        int          k;

        v = rand64();
        k = $urandom_range(0, 12);
        if (grp == GRP_BASE)
            v[0] = ($urandom_range(0, 7) != 0);
        else if (grp == GRP_MASK)
        begin
            case ($urandom_range(0, 3))
                0:       v = '0;
                1, 2:    v = ((64'd1 << k) - 64'd1) << 20;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Bus address that usually hits the compare bits of some window
    function automatic logic [63:0] aimed_address();
        logic [63:0] a;
        int          w;

        a = rand64();
        w = $urandom_range(0, NUM_WINDOWS_DEF - 1);
        if ($urandom_range(0, 3) != 0)
            a[31:20] = aim_base[w][31:20] ^ (a[43:32] & aim_mask[w][31:20]);
        return a;
    endfunction

    // One transfer: hold start until accepted, then maybe close the burst
    task automatic send_op(
        input logic [1:0]  fn,
        input logic [3:0]  idx,
        input logic [63:0] wd,
        input logic [63:0] ba,
        input logic [63:0] pe
    );
        start       <= 1'b1;
        func        <= fn;
        reg_index   <= idx;
        write_data  <= wd;
        bus_address <= ba;
        page_entry  <= pe;
        do
            @(posedge clk);
        while (busy);
        if (fn == FUNC_WRITE && idx[3:2] == GRP_BASE)
            aim_base[idx[1:0]] = wd;
        if (fn == FUNC_WRITE && idx[3:2] == GRP_MASK)
            aim_mask[idx[1:0]] = wd;
        sent_count++;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 7);
        end
        else
            burst_left--;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        logic [3:0] ridx;
        logic [1:0] rgrp;
        int         pick;
        bit         paused;

        paused = 1'b0;
        for (int i = 0; i < NUM_WINDOWS_DEF; i++)
        begin
            aim_base[i] = '0;
            aim_mask[i] = '0;
        end
        rst_n       <= 1'b0;
        start       <= 1'b0;
        func        <= FUNC_READ;
        reg_index   <= '0;
        write_data  <= '0;
        bus_address <= '0;
        page_entry  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, error and invalidate registers
        send_op(FUNC_READ,  REG_CTRL,    rand64(), rand64(), rand64());
        send_op(FUNC_READ,  REG_ERR,     rand64(), rand64(), rand64());
        send_op(FUNC_READ,  REG_ERRMASK, rand64(), rand64(), rand64());
        send_op(FUNC_READ,  REG_TLBIA,   rand64(), rand64(), rand64());
        send_op(FUNC_WRITE, REG_ERR,     '1,       rand64(), rand64());
        send_op(FUNC_WRITE, REG_ERRMASK, '1,       rand64(), rand64());
        send_op(FUNC_WRITE, REG_TLBIA,   '1,       rand64(), rand64());
        send_op(FUNC_WRITE, REG_CTRL,    '1,       rand64(), rand64());
        send_op(FUNC_READ,  REG_CTRL,    rand64(), rand64(), rand64());

        // page entry with no fetch pending, address with no window open
        send_op(FUNC_ENTRY, rand_idx(), rand64(), rand64(), '1);
        send_op(FUNC_XLATE, rand_idx(), rand64(), '1,       rand64());

        // direct window 0, top nibble of the compare bits only
        send_op(FUNC_WRITE, {GRP_BASE, 2'd0},  64'h0000_0000_8000_0001, rand64(), rand64());
        send_op(FUNC_WRITE, {GRP_MASK, 2'd0},  64'h0000_0000_0FF0_0000, rand64(), rand64());
        send_op(FUNC_WRITE, {GRP_TBASE, 2'd0}, '1, rand64(), rand64());
        send_op(FUNC_XLATE, rand_idx(), rand64(), 64'hFFFF_FFFF_8765_4321, rand64());

        // scatter-gather window 1: fetch request, then the entry comes back
        send_op(FUNC_WRITE, {GRP_BASE, 2'd1},  64'h0000_0000_4000_0003, rand64(), rand64());
        send_op(FUNC_WRITE, {GRP_TBASE, 2'd1}, '1, rand64(), rand64());
        send_op(FUNC_XLATE, rand_idx(), rand64(), 64'hFFFF_FFFF_400F_FFFF, rand64());
        send_op(FUNC_ENTRY, rand_idx(), rand64(), rand64(), '1);

        // a new translation while a fetch is pending drops the fetch
        send_op(FUNC_XLATE, rand_idx(), rand64(), 64'h0000_0000_4000_1234, rand64());
        send_op(FUNC_XLATE, rand_idx(), rand64(), 64'h0000_0000_8000_0000, rand64());
        send_op(FUNC_ENTRY, rand_idx(), rand64(), rand64(), '1);

        // matching but disabled window, then readback
        send_op(FUNC_WRITE, {GRP_BASE, 2'd2},  64'h0000_0000_C000_0002, rand64(), rand64());
        send_op(FUNC_XLATE, rand_idx(), rand64(), 64'h0000_0000_C000_0000, rand64());
        send_op(FUNC_READ,  {GRP_TBASE, 2'd1}, rand64(), rand64(), rand64());
        send_op(FUNC_WRITE, REG_CTRL, '0, rand64(), rand64());

        drain_results();

        // random traffic: mostly translations aimed at windows, with page entry returns
        while (sent_count < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            ridx = 4'($urandom_range(0, 15));
            rgrp = 2'($urandom_range(0, 2));
            if (pick < 12)
                send_op(FUNC_WRITE, {rgrp, ridx[1:0]}, window_value(rgrp), rand64(), rand64());
            else if (pick < 18)
                send_op(FUNC_WRITE, ridx, rand64(), rand64(), rand64());
            else if (pick < 28)
                send_op(FUNC_READ, ridx, rand64(), rand64(), rand64());
            else if (pick < 90)
            begin
                send_op(FUNC_XLATE, ridx, rand64(), aimed_address(), rand64());
                if ($urandom_range(0, 9) == 0)
                    send_op(FUNC_XLATE, ridx, rand64(), aimed_address(), rand64());
                if ($urandom_range(0, 9) < 7)
                    send_op(FUNC_ENTRY, ridx, rand64(), rand64(), rand64());
            end
            else
                send_op(FUNC_ENTRY, ridx, rand64(), rand64(), rand64());

            if (!paused && sent_count >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d transfers of every function through directed and random traffic.",
                 sent_count);
        $display("Checked %0d register, %0d address, %0d fetch and %0d error results.",
                 ack_count, addr_count, fetch_count, err_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
hdl/pdwt_pkg.sv
hdl/pdwt_window_bank.sv
hdl/pdwt_xlate.sv
hdl/pci_dma_window_translator_unit.sv
bench/pdwt_checker.sv
bench/tb_pci_dma_window_translator_unit.sv
